@@ rtl/core/ipmd_pkg.sv @@
// ----------------------------------------------------------------------------
// ipmd_pkg
// Shared types, constants and the microcode table of the PID motor drive.
// ----------------------------------------------------------------------------
package ipmd_pkg;

    localparam int GAIN_FRAC  = 8;
    localparam int PWM_OFFSET = 0;

    localparam int ANGLE_W = 16;
    localparam int ERR_W   = ANGLE_W + 1;
    localparam int OPND_W  = ERR_W + 2;
    localparam int GAIN_W  = 16;
    localparam int PROD_W  = OPND_W + GAIN_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int UW_W    = ACC_W + 1;
    localparam int DUTY_W  = 17;
    localparam int DPROD_W = DUTY_W + 16;
    localparam int CMPW_W  = DPROD_W - 15 + 1;
    localparam int STEP_W  = 4;

    localparam logic [15:0] OFF_VAL = (PWM_OFFSET > 65535) ? 16'hFFFF : 16'(PWM_OFFSET);

    localparam logic signed [ACC_W-1:0] RND_BIAS_POS = (ACC_W'(1) << GAIN_FRAC) >> 1;
    localparam logic signed [ACC_W-1:0] RND_BIAS_NEG =
        (RND_BIAS_POS == '0) ? '0 : RND_BIAS_POS - ACC_W'(1);

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_FWD  = 2'd1,
        DRV_REV  = 2'd2,
        DRV_TILT = 2'd3
    } drive_t;

    typedef enum logic [2:0] {
        CFG_SETPOINT    = 3'd0,
        CFG_KP          = 3'd1,
        CFG_KI_TERM     = 3'd2,
        CFG_KD_TERM     = 3'd3,
        CFG_U_MAX       = 3'd4,
        CFG_ANGLE_LIMIT = 3'd5,
        CFG_DEADBAND    = 3'd6,
        CFG_PWM_SPAN    = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ERR,
        UOP_LD_D1,
        UOP_MAC_P,
        UOP_LD_S,
        UOP_MAC_I,
        UOP_LD_DD,
        UOP_MAC_D,
        UOP_RND,
        UOP_ADD,
        UOP_SAT,
        UOP_DUTY,
        UOP_MULD,
        UOP_EMIT,
        UOP_CLR
    } uop_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_IF_CLEAR,
        JMP_END
    } jmp_t;

    typedef struct packed {
        uop_t              uop;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    localparam logic [STEP_W-1:0] STEP_CLR = STEP_W'(13);

    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '{uop: UOP_NOP, jmp: JMP_END, target: '0};
        case (step)
            4'd0:    cw = '{uop: UOP_ERR,   jmp: JMP_IF_CLEAR, target: STEP_CLR};
            4'd1:    cw = '{uop: UOP_LD_D1, jmp: JMP_NONE, target: '0};
            4'd2:    cw = '{uop: UOP_MAC_P, jmp: JMP_NONE, target: '0};
            4'd3:    cw = '{uop: UOP_LD_S,  jmp: JMP_NONE, target: '0};
            4'd4:    cw = '{uop: UOP_MAC_I, jmp: JMP_NONE, target: '0};
            4'd5:    cw = '{uop: UOP_LD_DD, jmp: JMP_NONE, target: '0};
            4'd6:    cw = '{uop: UOP_MAC_D, jmp: JMP_NONE, target: '0};
            4'd7:    cw = '{uop: UOP_RND,   jmp: JMP_NONE, target: '0};
            4'd8:    cw = '{uop: UOP_ADD,   jmp: JMP_NONE, target: '0};
            4'd9:    cw = '{uop: UOP_SAT,   jmp: JMP_NONE, target: '0};
            4'd10:   cw = '{uop: UOP_DUTY,  jmp: JMP_NONE, target: '0};
            4'd11:   cw = '{uop: UOP_MULD,  jmp: JMP_NONE, target: '0};
            4'd12:   cw = '{uop: UOP_EMIT,  jmp: JMP_END,  target: '0};
            4'd13:   cw = '{uop: UOP_CLR,   jmp: JMP_END,  target: '0};
            default: cw = '{uop: UOP_NOP,   jmp: JMP_END,  target: '0};
        endcase
        return cw;
    endfunction

endpackage

@@ rtl/core/incremental_pid_motor_drive_top.sv @@
// ----------------------------------------------------------------------------
// incremental_pid_motor_drive_top
// Velocity-form PID balance controller with saturation and PWM drive mapping.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// s_       in         s_tvalid/s_tready    tuser: op; tdata: angle
// m_       out        m_tvalid/m_tready    tuser: drive; tdata: control_out,
//                                          compare_first, compare_second
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A sample runs ROM steps ERR, LD_D1, MAC_P, LD_S, MAC_I, LD_DD, MAC_D, RND, ADD,
// SAT, DUTY, MULD and EMIT, a clear op ERR and CLR; the gains share one multiplier.
// s_tready is high whenever the sequencer is free, also while a result waits.
// The final step holds while the output register is still full and stalled.
// Reset loads register defaults and zeroes the history; no clearing pass.
// ----------------------------------------------------------------------------
module incremental_pid_motor_drive_top
    import ipmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] angle
    input  logic [0:0]  s_tuser,    // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] control_out, [31:16] compare_first,
                                    // [47:32] compare_second
    output logic [1:0]  m_tuser,    // [1:0] drive
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic signed [15:0] setpoint_reg, setpoint_next;
    logic [15:0]        kp_reg, kp_next;
    logic [15:0]        ki_reg, ki_next;
    logic [15:0]        kd_reg, kd_next;
    logic [15:0]        umax_reg, umax_next;
    logic [14:0]        alim_reg, alim_next;
    logic [14:0]        dband_reg, dband_next;
    logic [15:0]        span_reg, span_next;

    logic signed [ERR_W-1:0] e1_reg, e1_next;
    logic signed [ERR_W-1:0] e2_reg, e2_next;
    logic signed [15:0]      ol_reg, ol_next;

    logic                    busy_reg, busy_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    op_reg, op_next;
    logic signed [15:0]      angle_reg, angle_next;
    logic signed [ERR_W-1:0] e_reg, e_next;
    logic signed [OPND_W-1:0] opnd_reg, opnd_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [UW_W-1:0]  uw_reg, uw_next;
    drive_t                  drv_reg, drv_next;
    logic [DUTY_W-1:0]       duty_reg, duty_next;
    logic [DPROD_W-1:0]      dprod_reg, dprod_next;

    logic                    mvalid_reg, mvalid_next;
    logic [47:0]             mdata_reg, mdata_next;
    logic [1:0]              muser_reg, muser_next;

    ctrl_word_t              cw;
    logic                    stall;
    logic [GAIN_W-1:0]       gain_sel;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] rnd_sum;
    logic [15:0]             hi_mag;
    logic [16:0]             lo_mag;
    logic signed [UW_W-1:0]  hi_ext, lo_ext;
    logic signed [15:0]      u_sat;
    logic signed [ERR_W-1:0] angle_ext, alim_pos, alim_neg, db_pos, db_neg;
    logic [CMPW_W-1:0]       cmp_wide;
    logic [15:0]             cmp_val;

    assign s_tready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

    assign cw    = ucode_rom(step_reg);
    assign stall = (cw.jmp == JMP_END) && mvalid_reg && !m_tready;

    always_comb begin
        case (cw.uop)
            UOP_MAC_P: gain_sel = kp_reg;
            UOP_MAC_I: gain_sel = ki_reg;
            UOP_MAC_D: gain_sel = kd_reg;
            default:   gain_sel = '0;
        endcase
    end

    assign prod    = $signed({1'b0, gain_sel}) * opnd_reg;
    assign rnd_sum = acc_reg + (acc_reg[ACC_W-1] ? RND_BIAS_NEG : RND_BIAS_POS);

    assign hi_mag = (umax_reg < 16'd32767) ? umax_reg : 16'd32767;
    assign lo_mag = (umax_reg < 16'd32768) ? {1'b0, umax_reg} : 17'd32768;
    assign hi_ext = $signed({{(UW_W-16){1'b0}}, hi_mag});
    assign lo_ext = $signed(UW_W'(0) - {{(UW_W-17){1'b0}}, lo_mag});

    always_comb begin
        if (uw_reg > hi_ext) begin
            u_sat = hi_ext[15:0];
        end else if (uw_reg < lo_ext) begin
            u_sat = lo_ext[15:0];
        end else begin
            u_sat = uw_reg[15:0];
        end
    end

    assign angle_ext = {angle_reg[15], angle_reg};
    assign alim_pos  = $signed({2'b00, alim_reg});
    assign alim_neg  = $signed(ERR_W'(0) - {2'b00, alim_reg});
    assign db_pos    = $signed({2'b00, dband_reg});
    assign db_neg    = $signed(ERR_W'(0) - {2'b00, dband_reg});

    assign cmp_wide = {1'b0, dprod_reg[DPROD_W-1:15]} + CMPW_W'(PWM_OFFSET);
    assign cmp_val  = (cmp_wide > CMPW_W'(16'hFFFF)) ? 16'hFFFF : cmp_wide[15:0];

    always_comb begin
        setpoint_next = setpoint_reg;
        kp_next       = kp_reg;
        ki_next       = ki_reg;
        kd_next       = kd_reg;
        umax_next     = umax_reg;
        alim_next     = alim_reg;
        dband_next    = dband_reg;
        span_next     = span_reg;
        e1_next       = e1_reg;
        e2_next       = e2_reg;
        ol_next       = ol_reg;
        busy_next     = busy_reg;
        step_next     = step_reg;
        op_next       = op_reg;
        angle_next    = angle_reg;
        e_next        = e_reg;
        opnd_next     = opnd_reg;
        acc_next      = acc_reg;
        uw_next       = uw_reg;
        drv_next      = drv_reg;
        duty_next     = duty_reg;
        dprod_next    = dprod_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        mdata_next    = mdata_reg;
        muser_next    = muser_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SETPOINT:    setpoint_next = $signed(cfg_data);
                CFG_KP:          kp_next       = cfg_data;
                CFG_KI_TERM:     ki_next       = cfg_data;
                CFG_KD_TERM:     kd_next       = cfg_data;
                CFG_U_MAX:       umax_next     = cfg_data;
                CFG_ANGLE_LIMIT: alim_next     = cfg_data[14:0];
                CFG_DEADBAND:    dband_next    = cfg_data[14:0];
                CFG_PWM_SPAN:    span_next     = cfg_data;
                default:         ;
            endcase
        end

        if (!busy_reg) begin
            if (s_tvalid) begin
                busy_next  = 1'b1;
                step_next  = '0;
                op_next    = s_tuser[0];
                angle_next = $signed(s_tdata);
            end
        end else if (!stall) begin
            case (cw.uop)
                UOP_ERR:   e_next = angle_ext - {setpoint_reg[15], setpoint_reg};
                UOP_LD_D1: begin
                    opnd_next = OPND_W'(e_reg) - OPND_W'(e1_reg);
                    acc_next  = '0;
                end
                UOP_LD_S:  opnd_next = OPND_W'(e_reg) + OPND_W'(e1_reg);
                UOP_LD_DD: opnd_next = OPND_W'(e_reg) - (OPND_W'(e1_reg) <<< 1)
                                       + OPND_W'(e2_reg);
                UOP_MAC_P,
                UOP_MAC_I,
                UOP_MAC_D: acc_next = acc_reg + ACC_W'(prod);
                UOP_RND:   acc_next = rnd_sum >>> GAIN_FRAC;
                UOP_ADD:   uw_next = UW_W'(ol_reg) + UW_W'(acc_reg);
                UOP_SAT: begin
                    ol_next = u_sat;
                    e2_next = e1_reg;
                    e1_next = e_reg;
                    if (angle_ext > alim_pos || angle_ext < alim_neg) begin
                        drv_next = DRV_TILT;
                    end else if (e_reg >= db_pos) begin
                        drv_next = DRV_FWD;
                    end else if (e_reg <= db_neg) begin
                        drv_next = DRV_REV;
                    end else begin
                        drv_next = DRV_STOP;
                    end
                end
                UOP_DUTY: begin
                    case (drv_reg)
                        DRV_FWD: duty_next = ol_reg[15] ? '0 : {1'b0, ol_reg};
                        DRV_REV: duty_next = (ol_reg > 16'sd0) ? '0
                                           : DUTY_W'(0) - {ol_reg[15], ol_reg};
                        default: duty_next = '0;
                    endcase
                end
                UOP_MULD: dprod_next = duty_reg * span_reg;
                UOP_EMIT: begin
                    mvalid_next = 1'b1;
                    muser_next  = drv_reg;
                    case (drv_reg)
                        DRV_FWD: mdata_next = {cmp_val, OFF_VAL, ol_reg};
                        DRV_REV: mdata_next = {OFF_VAL, cmp_val, ol_reg};
                        default: mdata_next = {OFF_VAL, OFF_VAL, ol_reg};
                    endcase
                end
                UOP_CLR: begin
                    e1_next     = '0;
                    e2_next     = '0;
                    ol_next     = '0;
                    mvalid_next = 1'b1;
                    muser_next  = DRV_STOP;
                    mdata_next  = {OFF_VAL, OFF_VAL, 16'd0};
                end
                default: ;
            endcase

            case (cw.jmp)
                JMP_IF_CLEAR: step_next = op_reg ? cw.target : step_reg + STEP_W'(1);
                JMP_END:      busy_next = 1'b0;
                default:      step_next = step_reg + STEP_W'(1);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= '0;
            kp_reg       <= 16'd256;
            ki_reg       <= '0;
            kd_reg       <= '0;
            umax_reg     <= 16'd32768;
            alim_reg     <= 15'd11520;
            dband_reg    <= '0;
            span_reg     <= 16'd1000;
            e1_reg       <= '0;
            e2_reg       <= '0;
            ol_reg       <= '0;
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            mvalid_reg   <= 1'b0;
        end else begin
            setpoint_reg <= setpoint_next;
            kp_reg       <= kp_next;
            ki_reg       <= ki_next;
            kd_reg       <= kd_next;
            umax_reg     <= umax_next;
            alim_reg     <= alim_next;
            dband_reg    <= dband_next;
            span_reg     <= span_next;
            e1_reg       <= e1_next;
            e2_reg       <= e2_next;
            ol_reg       <= ol_next;
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            mvalid_reg   <= mvalid_next;
        end
        op_reg    <= op_next;
        angle_reg <= angle_next;
        e_reg     <= e_next;
        opnd_reg  <= opnd_next;
        acc_reg   <= acc_next;
        uw_reg    <= uw_next;
        drv_reg   <= drv_next;
        duty_reg  <= duty_next;
        dprod_reg <= dprod_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

endmodule

@@ rtl/core/ipmd_checker.sv @@
// ----------------------------------------------------------------------------
// ipmd_checker
// Port-level checks of the PID motor drive, bound to the top level.
// ----------------------------------------------------------------------------
module ipmd_checker
    import ipmd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_second_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != DRV_FWD |-> m_tdata[47:32] == OFF_VAL)
        else $error("second compare active outside forward drive");

    a_first_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != DRV_REV |-> m_tdata[31:16] == OFF_VAL)
        else $error("first compare active outside reverse drive");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after a transfer");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind incremental_pid_motor_drive_top ipmd_checker u_ipmd_checker (.*);
